// ===== rtl/stt_pkg.sv =====
package stt_pkg;

	localparam int TOKEN_LENGTH_CAP_DEF = 100;
	localparam int LINE_BITS_DEF = 16;
	localparam int OFFSET_BITS_DEF = 24;
	localparam int NWORDS = 20;
	localparam int NKEYWORDS = 15;
	localparam int MAXWLEN = 9;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} stt_in_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [4:0]  word_index;
		logic [6:0]  token_length;
		logic [15:0] line_number;
		logic [23:0] start_offset;
		logic        last_of_run;
	} stt_out_t;

	typedef enum logic [3:0] {
		KIND_KEYWORD = 4'd0, KIND_TYPE = 4'd1, KIND_IDENT = 4'd2, KIND_NUMBER = 4'd3,
		KIND_SEMI = 4'd4, KIND_COMMA = 4'd5, KIND_OPER = 4'd6, KIND_ASSIGN = 4'd7,
		KIND_LPAREN = 4'd8, KIND_RPAREN = 4'd9, KIND_LBRACE = 4'd10,
		KIND_RBRACE = 4'd11, KIND_LBRACK = 4'd12, KIND_RBRACK = 4'd13,
		KIND_QUOTE = 4'd14, KIND_UNKNOWN = 4'd15
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_OP, MODE_DOT, MODE_NUM, MODE_WORD,
		MODE_LINEC, MODE_BLOCK, MODE_BSTAR
	} mode_t;

	// Classified character, produced by the front part.
	typedef enum logic [3:0] {
		CC_ZERO, CC_WS, CC_NL, CC_DELIM, CC_OPER, CC_EQ, CC_SLASH, CC_STAR,
		CC_DIGIT, CC_DOT, CC_ALPHA, CC_OTHER
	} cclass_t;

	typedef struct packed {
		logic [7:0] ch;
		cclass_t    cls;
		logic [3:0] dkind;
		logic       eot;
	} stt_cls_t;

	// Token record passed from the scanner to the output queue, before the
	// final-result mark is known.
	typedef struct packed {
		logic [3:0]  kind;
		logic [4:0]  idx;
		logic [7:0]  len;
		logic [31:0] line;
		logic [31:0] start;
	} stt_tok_t;

	function automatic logic [7:0] word_char(input int w, input int p);
		string s;
		begin
			case (w)
				0: s = "if"; 1: s = "else"; 2: s = "while"; 3: s = "for";
				4: s = "return"; 5: s = "class"; 6: s = "public"; 7: s = "private";
				8: s = "static"; 9: s = "void"; 10: s = "using"; 11: s = "namespace";
				12: s = "new"; 13: s = "try"; 14: s = "catch"; 15: s = "int";
				16: s = "float"; 17: s = "double"; 18: s = "char"; default: s = "bool";
			endcase
			word_char = (p < s.len()) ? s[p] : 8'd0;
		end
	endfunction

	function automatic logic [3:0] word_len(input int w);
		logic [3:0] l;
		begin
			l = 4'd0;
			for (int p = 0; p < MAXWLEN; p++)
				if (word_char(w, p) != 8'd0) l = l + 4'd1;
			word_len = l;
		end
	endfunction

endpackage

// ===== rtl/stt_classify.sv =====
module stt_classify import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  stt_in_t  din,
	output logic     cls_valid,
	input  logic     cls_ready,
	output stt_cls_t cls
);

	stt_cls_t c;
	logic [7:0] b;

	always_comb begin
		b = din.text_byte;
		c.ch = b;
		c.eot = din.end_of_text;
		c.dkind = KIND_UNKNOWN;
		c.cls = CC_OTHER;
		unique case (b)
			";": begin c.cls = CC_DELIM; c.dkind = KIND_SEMI; end
			",": begin c.cls = CC_DELIM; c.dkind = KIND_COMMA; end
			"(": begin c.cls = CC_DELIM; c.dkind = KIND_LPAREN; end
			")": begin c.cls = CC_DELIM; c.dkind = KIND_RPAREN; end
			"{": begin c.cls = CC_DELIM; c.dkind = KIND_LBRACE; end
			"}": begin c.cls = CC_DELIM; c.dkind = KIND_RBRACE; end
			"[": begin c.cls = CC_DELIM; c.dkind = KIND_LBRACK; end
			"]": begin c.cls = CC_DELIM; c.dkind = KIND_RBRACK; end
			"\"": begin c.cls = CC_DELIM; c.dkind = KIND_QUOTE; end
			"=": c.cls = CC_EQ;
			"/": c.cls = CC_SLASH;
			"*": c.cls = CC_STAR;
			"+", "-", ">", "<", "!": c.cls = CC_OPER;
			".": c.cls = CC_DOT;
			8'd10: c.cls = CC_NL;
			8'd0: c.cls = CC_ZERO;
			default: begin
				if (b == 8'd32 || (b >= 8'd9 && b <= 8'd13)) c.cls = CC_WS;
				else if (b >= "0" && b <= "9") c.cls = CC_DIGIT;
				else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_")
					c.cls = CC_ALPHA;
			end
		endcase
		if (din.end_of_text) c.cls = CC_ZERO;
	end

	// Two-entry queue toward the scanner.
	stt_cls_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic do_w, do_r;

	assign full = cnt_q == 2'd2;
	assign do_w = push && !full;
	assign cls_valid = cnt_q != 2'd0;
	assign do_r = cls_valid && cls_ready;
	assign cls = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_w) wr_q <= ~wr_q;
			if (do_r) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_w} - {1'b0, do_r};
		end
	end

	always_ff @(posedge clk) begin
		if (do_w) q_q[wr_q] <= c;
	end

endmodule

// ===== rtl/stt_scan.sv =====
module stt_scan import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cls_valid,
	output logic     cls_ready,
	input  stt_cls_t cls,
	input  logic     space_ok,
	output logic [1:0] tok_n,
	output stt_tok_t tok0,
	output stt_tok_t tok1
);

	// The result fields have fixed widths, so these limits are fixed as well.
	localparam int TOKEN_LENGTH_CAP = TOKEN_LENGTH_CAP_DEF;
	localparam int LINE_BITS = LINE_BITS_DEF;
	localparam int OFFSET_BITS = OFFSET_BITS_DEF;

	localparam logic [7:0] LCAP = 8'(TOKEN_LENGTH_CAP - 1);
	localparam logic [LINE_BITS-1:0] LMAX = '1;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;

	mode_t mode_q, mode_d;
	logic [7:0] held_q, held_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [OFFSET_BITS-1:0] pos_q, start_q, start_d;
	logic [7:0] len_q, len_d;
	logic [NWORDS-1:0] mask_q, mask_d;
	logic dot_q, dot_d;

	logic go;
	assign cls_ready = space_ok;
	assign go = cls_valid && space_ok;

	function automatic stt_tok_t mk(input logic [3:0] k, input logic [4:0] i,
			input logic [7:0] l, input logic [LINE_BITS-1:0] ln,
			input logic [OFFSET_BITS-1:0] s);
		stt_tok_t t;
		begin
			t.kind = k; t.idx = i; t.len = l;
			t.line = 32'(ln); t.start = 32'(s);
			mk = t;
		end
	endfunction

	// Narrow the candidate mask with one more character.
	function automatic logic [NWORDS-1:0] narrow(input logic [NWORDS-1:0] m,
			input logic [7:0] l, input logic [7:0] ch);
		logic [NWORDS-1:0] r;
		begin
			r = m;
			for (int w = 0; w < NWORDS; w++)
				if (l >= 8'(word_len(w)) || word_char(w, int'(l[3:0])) != ch) r[w] = 1'b0;
			narrow = r;
		end
	endfunction

	stt_tok_t pend;
	logic pend_v;
	logic [4:0] widx;
	logic [3:0] wkind;

	always_comb begin
		wkind = KIND_IDENT;
		widx = 5'd0;
		for (int w = 0; w < NWORDS; w++)
			if (mask_q[w] && len_q == 8'(word_len(w))) begin
				wkind = (w < NKEYWORDS) ? KIND_KEYWORD : KIND_TYPE;
				widx = 5'(w);
			end
		pend_v = 1'b1;
		unique case (mode_q)
			MODE_OP: pend = mk((held_q == "=") ? KIND_ASSIGN : KIND_OPER, 5'd0, 8'd1,
				line_q, start_q);
			MODE_DOT: pend = mk(KIND_UNKNOWN, 5'd0, 8'd1, line_q, start_q);
			MODE_NUM: pend = mk(KIND_NUMBER, 5'd0, len_q, line_q, start_q);
			MODE_WORD: pend = mk(wkind, widx, len_q, line_q, start_q);
			default: begin
				pend = mk(KIND_UNKNOWN, 5'd0, 8'd1, line_q, start_q);
				pend_v = 1'b0;
			end
		endcase
	end

	logic flush, nl;
	logic [LINE_BITS-1:0] line_inc;

	always_comb begin
		mode_d = mode_q; held_d = held_q; line_d = line_q; start_d = start_q;
		len_d = len_q; mask_d = mask_q; dot_d = dot_q;
		tok_n = 2'd0; tok0 = pend; tok1 = pend;
		flush = 1'b0; nl = 1'b0;
		line_inc = (line_q < LMAX) ? line_q + 1'b1 : line_q;
		if (cls.cls == CC_ZERO) begin
			tok_n = {1'b0, pend_v};
			mode_d = MODE_IDLE; held_d = 8'd0; line_d = LINE_BITS'(1);
			start_d = '0; len_d = 8'd0; mask_d = '1; dot_d = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_OP: begin
					if (held_q == "/" && cls.cls == CC_SLASH) mode_d = MODE_LINEC;
					else if (held_q == "/" && cls.cls == CC_STAR) mode_d = MODE_BLOCK;
					else if (cls.cls == CC_EQ) begin
						tok_n = 2'd1;
						tok0 = mk(KIND_ASSIGN, 5'd0, 8'd2, line_q, start_q);
						mode_d = MODE_IDLE;
					end else flush = 1'b1;
				end
				MODE_DOT: begin
					if (cls.cls == CC_DIGIT) begin
						mode_d = MODE_NUM; dot_d = 1'b1;
						len_d = (LCAP > 8'd1) ? 8'd2 : 8'd1;
					end else flush = 1'b1;
				end
				MODE_NUM: begin
					if (cls.cls == CC_DIGIT || (cls.cls == CC_DOT && !dot_q)) begin
						if (cls.cls == CC_DOT) dot_d = 1'b1;
						if (len_q < LCAP) len_d = len_q + 8'd1;
					end else flush = 1'b1;
				end
				MODE_WORD: begin
					if (cls.cls == CC_ALPHA || cls.cls == CC_DIGIT) begin
						if (len_q < LCAP) begin
							mask_d = narrow(mask_q, len_q, cls.ch);
							len_d = len_q + 8'd1;
						end
					end else flush = 1'b1;
				end
				MODE_LINEC: begin
					if (cls.cls == CC_NL) begin nl = 1'b1; mode_d = MODE_IDLE; end
				end
				MODE_BLOCK: begin
					if (cls.cls == CC_STAR) mode_d = MODE_BSTAR;
					else if (cls.cls == CC_NL) nl = 1'b1;
				end
				MODE_BSTAR: begin
					if (cls.cls == CC_SLASH) mode_d = MODE_IDLE;
					else if (cls.cls == CC_NL) begin nl = 1'b1; mode_d = MODE_BLOCK; end
					else if (cls.cls != CC_STAR) mode_d = MODE_BLOCK;
				end
				default: flush = 1'b1;
			endcase
			if (flush) begin
				// Pending token (if any) goes out first, then the new character starts.
				tok0 = pend;
				tok_n = {1'b0, pend_v};
				mode_d = MODE_IDLE;
				unique case (cls.cls)
					CC_DELIM, CC_OTHER: begin
						if (pend_v) begin
							tok1 = mk(cls.dkind, 5'd0, 8'd1, line_q, pos_q);
							tok_n = 2'd2;
						end else begin
							tok0 = mk(cls.dkind, 5'd0, 8'd1, line_q, pos_q);
							tok_n = 2'd1;
						end
					end
					CC_WS: ;
					CC_NL: nl = 1'b1;
					CC_OPER, CC_EQ, CC_SLASH, CC_STAR: begin
						start_d = pos_q; held_d = cls.ch; mode_d = MODE_OP;
					end
					CC_DIGIT: begin
						start_d = pos_q; mode_d = MODE_NUM; len_d = 8'd1; dot_d = 1'b0;
					end
					CC_DOT: begin start_d = pos_q; mode_d = MODE_DOT; end
					CC_ALPHA: begin
						start_d = pos_q; mode_d = MODE_WORD;
						if (LCAP > 8'd0) begin
							mask_d = narrow('1, 8'd0, cls.ch);
							len_d = 8'd1;
						end else begin
							mask_d = '1;
							len_d = 8'd0;
						end
					end
					default: ;
				endcase
			end
			if (nl) line_d = line_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE; held_q <= 8'd0; line_q <= LINE_BITS'(1);
			pos_q <= '0; start_q <= '0; len_q <= 8'd0; mask_q <= '1; dot_q <= 1'b0;
		end else if (go) begin
			mode_q <= mode_d; held_q <= held_d; line_q <= line_d; start_q <= start_d;
			len_q <= len_d; mask_q <= mask_d; dot_q <= dot_d;
			if (cls.cls == CC_ZERO) pos_q <= '0;
			else if (pos_q < OMAX) pos_q <= pos_q + 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (tok_n != 2'd2 || !go))
		else $error("two tokens from idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(go && cls.cls == CC_ZERO) |=> (mode_q == MODE_IDLE && line_q == LINE_BITS'(1)))
		else $error("end of text did not reset");
	assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_WORD || mode_q == MODE_NUM) |-> (len_q != 8'd0 && len_q <= LCAP))
		else $error("length out of range");

endmodule

// ===== rtl/stt_outq.sv =====
module stt_outq import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [1:0] tok_n,
	input  logic     tok_go,
	input  stt_tok_t tok0,
	input  stt_tok_t tok1,
	output logic     space_ok,
	output logic     empty,
	input  logic     pop,
	output stt_out_t dout
);

	localparam int DEPTH = 4;
	stt_out_t mem_q [DEPTH];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic do_r;
	logic [2:0] nw;
	stt_out_t e0, e1;

	function automatic stt_out_t cv(input stt_tok_t t, input logic last);
		stt_out_t o;
		begin
			o.token_kind = t.kind; o.word_index = t.idx; o.token_length = t.len[6:0];
			o.line_number = t.line[15:0]; o.start_offset = t.start[23:0];
			o.last_of_run = last;
			cv = o;
		end
	endfunction

	assign e0 = cv(tok0, tok_n == 2'd1);
	assign e1 = cv(tok1, 1'b1);
	assign space_ok = cnt_q <= 3'd2;
	assign empty = cnt_q == 3'd0;
	assign do_r = pop && !empty;
	assign dout = mem_q[rd_q];
	assign nw = tok_go ? {1'b0, tok_n} : 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0; rd_q <= 2'd0; cnt_q <= 3'd0;
		end else begin
			wr_q <= wr_q + nw[1:0];
			if (do_r) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + nw - {2'b0, do_r};
		end
	end

	always_ff @(posedge clk) begin
		if (nw != 3'd0) mem_q[wr_q] <= e0;
		if (nw == 3'd2) mem_q[wr_q + 2'd1] <= e1;
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'(DEPTH))
		else $error("output queue overflow");

endmodule

// ===== rtl/source_text_tokenizer_unit.sv =====
// A byte is classified and held in the front queue at the edge that
// accepts it; the scanner consumes it from there once the result queue has
// room, and its tokens are written into the result queue at that same edge.
// Throughput: one byte per cycle, stalled only while the result queue lacks
// room for two tokens, which happens when results are not popped.
// Reset: arst_n clears the queues and returns the scanner to line one, offset zero.
module source_text_tokenizer_unit import stt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  stt_in_t  din,
	output logic     empty,
	input  logic     pop,
	output stt_out_t dout
);

	// Front part: classify the byte and hold it in a small queue.
	logic cls_valid, cls_ready, space_ok;
	stt_cls_t cls;
	logic [1:0] tok_n;
	stt_tok_t tok0, tok1;

	stt_classify u_cls (
		.clk, .arst_n, .push, .full, .din,
		.cls_valid, .cls_ready, .cls
	);

	// Back part: the scanning state machine, which emits up to two tokens
	// per transaction whenever the output queue has room for both.
	stt_scan u_scan (
		.clk, .arst_n, .cls_valid, .cls_ready, .cls, .space_ok,
		.tok_n, .tok0, .tok1
	);

	// Result queue: the final token of each transaction carries last_of_run.
	stt_outq u_outq (
		.clk, .arst_n, .tok_n, .tok_go(cls_valid && cls_ready),
		.tok0, .tok1, .space_ok, .empty, .pop, .dout
	);

endmodule
